### hdl/modem_response_line_classifier_macros.svh
// Assertion helpers for the modem response line classifier.
// Both expect i_clk and i_rst_n in scope.
`ifndef MODEM_RESPONSE_LINE_CLASSIFIER_MACROS_SVH
`define MODEM_RESPONSE_LINE_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define MRLC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mrlc check failed");

// next-cycle implication
`define MRLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mrlc check failed");

`endif

### hdl/mrlc_pkg.sv
package mrlc_pkg;

    localparam int unsigned LINE_LIMIT = 128;
    localparam int unsigned CNT_W      = $clog2(LINE_LIMIT);
    localparam int unsigned NUM_KEYS   = 24;
    localparam int unsigned KEY_W      = $clog2(NUM_KEYS);
    localparam int unsigned KEY_CHARS  = 11;
    localparam int unsigned CLASS_W    = 5;
    localparam int unsigned RATE_W     = 20;
    localparam int unsigned OUT_TDATA_W = ((CLASS_W + RATE_W + 7) / 8) * 8;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [RATE_W-1:0] RATE_MAX      = '1;
    localparam logic [RATE_W-1:0] DEFAULT_RATE_RST = RATE_W'(300);

    localparam logic [CLASS_W-1:0] CLS_UNKNOWN = 5'd0;
    localparam logic [CLASS_W-1:0] CLS_CONNECT = 5'd22;

    // keys below this index are tried in order, the last hit wins
    localparam int unsigned KEY_CONNECT = 22;
    localparam int unsigned KEY_CARRIER = 23;
    localparam logic [CNT_W-1:0] SPACE_POS = CNT_W'(7);
    localparam logic [CNT_W-1:0] LAST_POS  = CNT_W'(LINE_LIMIT - 1);

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef struct packed {
        logic [8*KEY_CHARS-1:0] text;   // left-justified, first char in top byte
        logic [3:0]             len;
        logic                   prefix;
        logic                   fold;
        logic [CLASS_W-1:0]     cls;
    } t_key;

    function automatic t_key mk_key(input logic [8*KEY_CHARS-1:0] s, input logic [3:0] len,
                                    input logic prefix, input logic fold,
                                    input logic [CLASS_W-1:0] cls);
        t_key k;
        k.text   = s << (8 * (KEY_CHARS - len));
        k.len    = len;
        k.prefix = prefix;
        k.fold   = fold;
        k.cls    = cls;
        return k;
    endfunction

    function automatic t_key key_info(input logic [KEY_W-1:0] idx);
        t_key k;
        unique case (idx)
            5'd0:    k = mk_key("+FHS:", 4'd5, 1'b1, 1'b0, 5'd10);
            5'd1:    k = mk_key("+FCO:", 4'd5, 1'b1, 1'b0, 5'd11);
            5'd2:    k = mk_key("+FPO", 4'd4, 1'b1, 1'b0, 5'd12);
            5'd3:    k = mk_key("+FVO", 4'd4, 1'b1, 1'b0, 5'd13);
            5'd4:    k = mk_key("+FIS:", 4'd5, 1'b1, 1'b0, 5'd14);
            5'd5:    k = mk_key("+FNF:", 4'd5, 1'b1, 1'b0, 5'd15);
            5'd6:    k = mk_key("+FCI:", 4'd5, 1'b1, 1'b0, 5'd16);
            5'd7:    k = mk_key("+FPS:", 4'd5, 1'b1, 1'b0, 5'd17);
            5'd8:    k = mk_key("+FCS:", 4'd5, 1'b1, 1'b0, 5'd18);
            5'd9:    k = mk_key("+FNS:", 4'd5, 1'b1, 1'b0, 5'd19);
            5'd10:   k = mk_key("+FTI:", 4'd5, 1'b1, 1'b0, 5'd20);
            5'd11:   k = mk_key("+FET:", 4'd5, 1'b1, 1'b0, 5'd21);
            5'd12:   k = mk_key("BUSY", 4'd4, 1'b0, 1'b1, 5'd1);
            5'd13:   k = mk_key("ERROR", 4'd5, 1'b0, 1'b1, 5'd2);
            5'd14:   k = mk_key("NO ANSWER", 4'd9, 1'b0, 1'b1, 5'd3);
            5'd15:   k = mk_key("NO CARRIER", 4'd10, 1'b0, 1'b1, 5'd4);
            5'd16:   k = mk_key("NO DIALTONE", 4'd11, 1'b0, 1'b1, 5'd5);
            5'd17:   k = mk_key("OK", 4'd2, 1'b0, 1'b1, 5'd6);
            5'd18:   k = mk_key("RING", 4'd4, 1'b0, 1'b1, 5'd7);
            5'd19:   k = mk_key("RINGING", 4'd7, 1'b0, 1'b1, 5'd8);
            5'd20:   k = mk_key("VOICE", 4'd5, 1'b0, 1'b1, 5'd9);
            5'd21:   k = mk_key("CONNECT FAX", 4'd11, 1'b0, 1'b1, 5'd11);
            5'd22:   k = mk_key("CONNECT", 4'd7, 1'b1, 1'b1, CLS_CONNECT);
            5'd23:   k = mk_key("CARRIER", 4'd7, 1'b1, 1'b1, CLS_CONNECT);
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

### hdl/modem_response_line_classifier.sv
// A carriage return is held in the input reg; its result is registered into the output reg once m_axis is free.
// Throughput: one byte per cycle; a carriage return waits in the input reg while a result is unaccepted.
// Per-byte work is the 24-keyword match plus the x10 rate update, done combinationally from the input reg.
// Reset (synchronous, i_rst_n low): line state cleared, both valids low, default_rate = 300.
`include "modem_response_line_classifier_macros.svh"
module modem_response_line_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // byte stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] rx_byte
    // results out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [mrlc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [4:0] response_class,
                                                                // [24:5] line_rate, rest 0
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mrlc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mrlc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mrlc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import mrlc_pkg::*;

    typedef enum logic [1:0] {
        NP_BLANK,
        NP_SIGN,
        NP_DIGITS,
        NP_STOP
    } t_num_phase;

    logic [RATE_W-1:0]   r_default_rate;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_out_valid;
    logic [CLASS_W-1:0]  r_out_class;
    logic [RATE_W-1:0]   r_out_rate;

    logic [CNT_W-1:0]    r_count,   n_count;
    logic [NUM_KEYS-1:0] r_alive,   n_alive;
    logic [RATE_W-1:0]   r_rate,    n_rate;
    t_num_phase          r_phase,   n_phase;
    logic                r_space7,  n_space7;
    logic                r_ended,   n_ended;

    logic                is_cr;
    logic                out_free;
    logic                proc;
    logic                cfg_wr;
    logic [7:0]          c_up;
    logic                is_digit;
    logic                is_blank;
    logic [RATE_W+3:0]   rate_mac;
    t_key                key;
    t_key                key_m;
    logic [3:0]          pos;
    logic [7:0]          want;
    logic                ok;
    logic [NUM_KEYS-1:0] hit;
    logic [CLASS_W-1:0]  res_class;
    logic [RATE_W-1:0]   res_rate;
    logic [RATE_W-1:0]   conn_rate;

    assign is_cr    = (r_in_byte == CH_CR);
    assign out_free = !r_out_valid || m_axis_tready;
    assign proc     = r_in_valid && (!is_cr || out_free);
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[APB_ADDR_W-1] == 1'b0);

    assign s_axis_tready = !r_in_valid || proc;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_rate, r_out_class});
    assign pready        = 1'b1;
    assign prdata        = (paddr[APB_ADDR_W-1] == 1'b0) ?
                           APB_DATA_W'(r_default_rate) : '0;

    assign c_up     = ((r_in_byte >= CH_LC_A) && (r_in_byte <= CH_LC_Z)) ?
                      (r_in_byte & ~CASE_BIT) : r_in_byte;
    assign is_digit = (r_in_byte >= CH_ZERO) && (r_in_byte <= CH_NINE);
    assign is_blank = (r_in_byte == CH_SPACE) || (r_in_byte == CH_TAB) ||
                      (r_in_byte == CH_VT) || (r_in_byte == CH_FF);
    assign rate_mac = (RATE_W+4)'({r_rate, 3'b000}) + (RATE_W+4)'({r_rate, 1'b0}) +
                      (RATE_W+4)'(r_in_byte - CH_ZERO);
    assign pos      = r_count[3:0];

    // line classification from the state left by the bytes so far
    always_comb begin
        res_class = CLS_UNKNOWN;
        res_rate  = '0;
        key       = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            key    = key_info(KEY_W'(k));
            hit[k] = r_alive[k] && (key.prefix ? (r_count >= CNT_W'(key.len)) :
                                                 (r_count == CNT_W'(key.len)));
            if (k < KEY_CONNECT && hit[k]) begin
                res_class = key.cls;
            end
        end
        conn_rate = r_space7 ? r_rate : r_default_rate;
        if (res_class == CLS_UNKNOWN && (hit[KEY_CONNECT] || hit[KEY_CARRIER]) &&
            conn_rate != '0) begin
            res_class = CLS_CONNECT;
            res_rate  = conn_rate;
        end
    end

    always_comb begin
        n_count  = r_count;
        n_alive  = r_alive;
        n_rate   = r_rate;
        n_phase  = r_phase;
        n_space7 = r_space7;
        n_ended  = r_ended;
        key_m    = '0;
        want     = '0;
        ok       = 1'b0;
        if (proc) begin
            if (is_cr) begin
                n_count  = '0;
                n_alive  = '1;
                n_rate   = '0;
                n_phase  = NP_BLANK;
                n_space7 = 1'b0;
                n_ended  = 1'b0;
            end else if (r_in_byte == CH_LF || r_ended || r_count >= LAST_POS) begin
                // byte dropped
            end else if (r_in_byte == CH_NUL) begin
                n_ended = 1'b1;
            end else begin
                for (int k = 0; k < NUM_KEYS; k++) begin
                    key_m = key_info(KEY_W'(k));
                    want  = 8'(key_m.text >> {(4'(KEY_CHARS - 1) - pos), 3'b000});
                    if (r_count < CNT_W'(key_m.len)) begin
                        ok = key_m.fold ? (c_up == want) : (r_in_byte == want);
                    end else begin
                        ok = key_m.prefix;
                    end
                    if (!ok) begin
                        n_alive[k] = 1'b0;
                    end
                end
                if (r_count == SPACE_POS) begin
                    n_space7 = (r_in_byte == CH_SPACE);
                end else if (r_count > SPACE_POS && r_space7) begin
                    priority if (r_phase == NP_BLANK && is_blank) begin
                        // skip leading blanks
                    end else if (r_phase == NP_BLANK && r_in_byte == CH_PLUS) begin
                        n_phase = NP_SIGN;
                    end else if (r_phase == NP_BLANK && r_in_byte == CH_MINUS) begin
                        n_phase = NP_STOP;
                    end else if (r_phase != NP_STOP && is_digit) begin
                        n_rate  = (rate_mac > (RATE_W+4)'(RATE_MAX)) ? RATE_MAX :
                                  rate_mac[RATE_W-1:0];
                        n_phase = NP_DIGITS;
                    end else begin
                        n_phase = NP_STOP;
                    end
                end
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_rate <= DEFAULT_RATE_RST;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_count        <= '0;
            r_alive        <= '1;
            r_rate         <= '0;
            r_phase        <= NP_BLANK;
            r_space7       <= 1'b0;
            r_ended        <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_default_rate <= pwdata[RATE_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= proc && is_cr;
            end
            r_count  <= n_count;
            r_alive  <= n_alive;
            r_rate   <= n_rate;
            r_phase  <= n_phase;
            r_space7 <= n_space7;
            r_ended  <= n_ended;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (proc && is_cr) begin
            r_out_class <= res_class;
            r_out_rate  <= res_rate;
        end
    end

    `MRLC_ASSERT_NOW(a_rate_only_on_connect, r_out_valid && r_out_class != CLS_CONNECT,
        r_out_rate == '0)
    `MRLC_ASSERT_NOW(a_class_range, r_out_valid, r_out_class <= CLS_CONNECT)
    `MRLC_ASSERT_NOW(a_count_bound, 1'b1, r_count <= LAST_POS)
    `MRLC_ASSERT_NEXT(a_cr_clears_line, proc && is_cr,
        r_count == '0 && r_alive == '1 && r_out_valid)

endmodule

### tb/tb_modem_response_line_classifier.sv
module tb_modem_response_line_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import mrlc_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int REG_DEFAULT_RATE = 0;
    localparam logic [APB_ADDR_W-1:0] ADDR_DEFAULT_RATE = APB_ADDR_W'(4 * REG_DEFAULT_RATE);

    typedef enum logic [CLASS_W-1:0] {
        RC_UNKNOWN, RC_BUSY, RC_ERROR, RC_NO_ANSWER, RC_NO_CARRIER, RC_NO_DIALTONE,
        RC_OK, RC_RING, RC_RINGING, RC_VOICE, RC_FHS, RC_FCO, RC_FPO, RC_FVO, RC_FIS,
        RC_FNF, RC_FCI, RC_FPS, RC_FCS, RC_FNS, RC_FTI, RC_FET, RC_CONNECT
    } t_resp_class;

    typedef enum logic [1:0] {
        NUM_BLANKS, NUM_SIGNED, NUM_DIGITS, NUM_STOPPED
    } t_num_phase;

    typedef struct packed {
        t_resp_class        cls;
        logic [RATE_W-1:0]  rate;
    } t_verdict;

    string kw_text [NUM_KEYS] = '{
        "+FHS:", "+FCO:", "+FPO", "+FVO", "+FIS:", "+FNF:", "+FCI:", "+FPS:", "+FCS:",
        "+FNS:", "+FTI:", "+FET:", "BUSY", "ERROR", "NO ANSWER", "NO CARRIER",
        "NO DIALTONE", "OK", "RING", "RINGING", "VOICE", "CONNECT FAX", "CONNECT", "CARRIER"
    };
    t_resp_class kw_class [NUM_KEYS] = '{
        RC_FHS, RC_FCO, RC_FPO, RC_FVO, RC_FIS, RC_FNF, RC_FCI, RC_FPS, RC_FCS,
        RC_FNS, RC_FTI, RC_FET, RC_BUSY, RC_ERROR, RC_NO_ANSWER, RC_NO_CARRIER,
        RC_NO_DIALTONE, RC_OK, RC_RING, RC_RINGING, RC_VOICE, RC_FCO, RC_CONNECT, RC_CONNECT
    };
    // fax words and CONNECT/CARRIER match as prefixes, result words fold case
    localparam logic [NUM_KEYS-1:0] KW_PREFIX = 24'hC00FFF;
    localparam logic [NUM_KEYS-1:0] KW_FOLD   = 24'hFFF000;
    localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [7:0]                 s_axis_tdata = '0;     // [7:0] rx_byte
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;          // [4:0] class, [24:5] rate, rest 0
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]      paddr = '0;
    logic [APB_DATA_W-1:0]      pwdata = '0;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;

    // line classifier state mirrored from the block
    logic [RATE_W-1:0]          dflt_rate;
    int unsigned                line_len;
    logic [NUM_KEYS-1:0]        alive;
    logic [RATE_W-1:0]          rate_acc;
    t_num_phase                 num_phase;
    bit                         space_at_7;
    bit                         text_done;

    logic [7:0]                 line_bytes [$];
    t_verdict                   due_verdicts [$];
    int                         bytes_queued = 0;
    int                         mismatches = 0;
    int                         quiet_cycles = 0;
    int                         send_gap_pct = 23;
    int                         sink_gap_pct = 73;
    bit                         lf_noise = 1'b0;
    bit                         hold_armed = 1'b0;
    bit                         hold_done;
    int                         hold_left;

    modem_response_line_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic clear_line_state();
        line_len   = 0;
        alive      = '1;
        rate_acc   = '0;
        num_phase  = NUM_BLANKS;
        space_at_7 = 1'b0;
        text_done  = 1'b0;
    endtask

    function automatic bit key_hit(input int k);
        if (!alive[k])
            return 1'b0;
        return KW_PREFIX[k] ? (line_len >= kw_text[k].len()) : (line_len == kw_text[k].len());
    endfunction

    task automatic classify_char(input logic [7:0] c);
        t_verdict       v;
        logic [7:0]     want;
        logic [7:0]     cu;
        bit             ok;
        int unsigned    acc_wide;
        if (c == CH_CR) begin
            v.cls  = RC_UNKNOWN;
            v.rate = '0;
            for (int k = 0; k < KEY_CONNECT; k++)
                if (key_hit(k))
                    v.cls = kw_class[k];
            if (v.cls == RC_UNKNOWN && (key_hit(KEY_CONNECT) || key_hit(KEY_CARRIER))) begin
                v.rate = space_at_7 ? rate_acc : dflt_rate;
                v.cls  = (v.rate != 0) ? RC_CONNECT : RC_UNKNOWN;
            end
            due_verdicts.push_back(v);
            clear_line_state();
            return;
        end
        if (c == CH_LF || text_done || line_len >= LINE_LIMIT - 1)
            return;
        if (c == CH_NUL) begin
            text_done = 1'b1;
            return;
        end
        cu = (c >= CH_LC_A && c <= CH_LC_Z) ? (c - CASE_BIT) : c;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (line_len < kw_text[k].len()) begin
                want = kw_text[k][line_len];
                ok = KW_FOLD[k] ? (cu == want) : (c == want);
            end else begin
                ok = KW_PREFIX[k];
            end
            if (!ok)
                alive[k] = 1'b0;
        end
        if (line_len == 7) begin
            space_at_7 = (c == CH_SPACE);
        end else if (line_len >= 8 && space_at_7) begin
            if (num_phase == NUM_BLANKS &&
                (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)) begin
                // leading blank, skipped
            end else if (num_phase == NUM_BLANKS && (c == CH_PLUS || c == CH_MINUS)) begin
                num_phase = (c == CH_PLUS) ? NUM_SIGNED : NUM_STOPPED;
            end else if (num_phase != NUM_STOPPED && c >= CH_ZERO && c <= CH_NINE) begin
                acc_wide  = 32'(rate_acc) * 10 + 32'(c - CH_ZERO);
                rate_acc  = (acc_wide > RATE_MAX) ? RATE_MAX : acc_wide[RATE_W-1:0];
                num_phase = NUM_DIGITS;
            end else begin
                num_phase = NUM_STOPPED;
            end
        end
        line_len++;
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                classify_char(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (line_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= line_bytes.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver; one long hold-off while the sender keeps offering
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_armed && !hold_done && s_axis_tvalid) begin
            m_axis_tready <= 1'b0;
            hold_left     <= LONG_HOLD;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_gap_pct);
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_verdicts.size() == 0) begin
                $display("%0t: result with none expected, tdata 0x%h", $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = due_verdicts.pop_front();
                if (m_axis_tdata[CLASS_W-1:0] !== want.cls) begin
                    $display("%0t: class expected %0d, actual %0d",
                             $time, want.cls, m_axis_tdata[CLASS_W-1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[CLASS_W +: RATE_W] !== want.rate) begin
                    $display("%0t: rate expected %0d, actual %0d",
                             $time, want.rate, m_axis_tdata[CLASS_W +: RATE_W]);
                    mismatches++;
                end
                if (m_axis_tdata[OUT_TDATA_W-1:CLASS_W+RATE_W] !== '0) begin
                    $display("%0t: pad bits expected 0, actual 0x%h",
                             $time, m_axis_tdata[OUT_TDATA_W-1:CLASS_W+RATE_W]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no progress for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_access(input logic write_en, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= ADDR_DEFAULT_RATE;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_default_rate();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd[RATE_W-1:0] !== dflt_rate) begin
            $display("%0t: default_rate readback expected %0d, actual %0d",
                     $time, dflt_rate, rd[RATE_W-1:0]);
            mismatches++;
        end
    endtask

    task automatic program_default_rate(input logic [RATE_W-1:0] v);
        logic [APB_DATA_W-1:0] wd;
        logic [APB_DATA_W-1:0] rd;
        wd = $urandom();    // upper bits are don't-care
        wd[RATE_W-1:0] = v;
        apb_access(1'b1, wd, rd);
        dflt_rate = v;
        check_default_rate();
    endtask

    task automatic push_char(input logic [7:0] c);
        if (lf_noise && $urandom_range(99) < 3)
            line_bytes.push_back(CH_LF);
        line_bytes.push_back(c);
        bytes_queued++;
    endtask

    task automatic push_text(input string s, input bit mix_case);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++) begin
            ch = s[i];
            if (mix_case && ch >= "A" && ch <= "Z" && $urandom_range(1) == 1)
                ch = ch | CASE_BIT;
            push_char(ch);
        end
    endtask

    function automatic logic [7:0] random_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == CH_CR) ? CH_LF : b;
    endfunction

    task automatic push_random_line();
        int         kind;
        int         k;
        int         n;
        int         cut;
        int         bad_pos;
        int         r;
        logic [7:0] ch;
        string      w;
        kind = $urandom_range(99);
        if (kind < 28) begin
            // result word, random case, sometimes damaged
            k = $urandom_range(12, 21);
            w = kw_text[k];
            cut = ($urandom_range(99) < 10) ? w.len() - 1 : w.len();
            bad_pos = ($urandom_range(99) < 10) ? $urandom_range(w.len() - 1) : -1;
            for (int i = 0; i < cut; i++) begin
                ch = w[i];
                if (i == bad_pos)
                    ch = random_text_byte();
                else if (ch >= "A" && ch <= "Z" && $urandom_range(1) == 1)
                    ch = ch | CASE_BIT;
                push_char(ch);
            end
            if ($urandom_range(99) < 10)
                push_char(random_text_byte());
        end else if (kind < 42) begin
            k = $urandom_range(0, 11);
            push_text(kw_text[k], $urandom_range(99) < 10);
            n = $urandom_range(0, 6);
            repeat (n) push_char(8'($urandom_range(32, 126)));
        end else if (kind < 72) begin
            push_text(($urandom_range(1) == 1) ? "CONNECT" : "CARRIER", 1'b1);
            case ($urandom_range(9))
                0: begin
                end
                1: push_text("/ARQ", 1'b0);
                2: push_text(" FAX", 1'b1);
                default: begin
                    push_char(CH_SPACE);
                    n = $urandom_range(0, 2);
                    repeat (n) push_char(BLANKS[$urandom_range(3)]);
                    r = $urandom_range(9);
                    if (r == 0)
                        push_char(CH_MINUS);
                    else if (r < 3)
                        push_char(CH_PLUS);
                    n = ($urandom_range(99) < 80) ? $urandom_range(1, 7) : $urandom_range(0, 9);
                    repeat (n) push_char(8'($urandom_range(CH_ZERO, CH_NINE)));
                    if ($urandom_range(1) == 1)
                        push_text("/V42BIS", 1'b0);
                end
            endcase
        end else if (kind < 78) begin
            // empty line
        end else if (kind < 90) begin
            n = $urandom_range(1, 16);
            repeat (n) push_char(8'($urandom_range(255)));
        end else begin
            // over-long line, half of them keep a valid head
            n = $urandom_range(120, 180);
            if ($urandom_range(1) == 1) begin
                push_text("CONNECT 1200", 1'b1);
                repeat (n) push_char(CH_SPACE);
            end else begin
                repeat (n) push_char(random_text_byte());
            end
        end
        if ($urandom_range(99) < 4) begin
            push_char(CH_NUL);
            n = $urandom_range(0, 4);
            repeat (n) push_char(random_text_byte());
        end
        push_char(CH_CR);
    endtask

    task automatic wait_idle(input int settle);
        while (line_bytes.size() != 0 || s_axis_tvalid || due_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic run_random_lines(input int budget);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < budget)
            push_random_line();
        wait_idle(4);
    endtask

    string plain_lines [] = '{
        "OK", "BUSY", "error", "No Answer", "NO CARRIER", "no dialtone", "RING",
        "Ringing", "VOICE", "+FHS:00", "+FCO:", "+FPO", "+FVO", "+FIS:1,5,0", "+FNF:",
        "+FCI:\"5551234\"", "+FPS:1", "+FCS:0,5", "+FNS:", "+FTI:\"1\"", "+FET:2",
        "+fhs:0", "CONNECT", "CARRIER 2400", "CONNECT 9600/ARQ", "CONNECT  +28800",
        "CONNECT -1200", "CONNECT 0", "CONNECT 99999999", "CONNECT\t2400", "CONNECT FAX",
        "connect fax", "CONNECTED", "OKAY", ""
    };

    initial begin
        clear_line_state();
        dflt_rate = DEFAULT_RATE_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_default_rate();

        foreach (plain_lines[i]) begin
            push_text(plain_lines[i], 1'b0);
            push_char(CH_CR);
        end
        push_text("CONNECT", 1'b0);
        push_char(CH_SPACE);
        push_char(CH_VT);
        push_char(CH_FF);
        push_char(CH_TAB);
        push_text("+14400/ARQ", 1'b0);
        push_char(CH_CR);
        // zero byte ends the text
        push_text("OK", 1'b0);
        push_char(CH_NUL);
        push_text("XYZ", 1'b0);
        push_char(CH_CR);
        push_char(CH_NUL);
        push_char(CH_CR);
        push_char(8'hFF);
        push_char(CH_CR);
        // last kept character is the 127th: rate 5, the trailing 7 is dropped
        push_text("CONNECT ", 1'b0);
        repeat (118) push_char(CH_ZERO);
        push_text("57", 1'b0);
        push_char(CH_CR);
        push_text("CONNECT ", 1'b0);
        repeat (130) push_char(CH_NINE);
        push_char(CH_CR);
        wait_idle(4);

        lf_noise = 1'b1;
        program_default_rate('0);
        run_random_lines(400);

        send_gap_pct = 73;
        sink_gap_pct = 23;
        program_default_rate(RATE_MAX);
        run_random_lines(400);

        send_gap_pct = 0;
        sink_gap_pct = 0;
        hold_armed   = 1'b1;
        program_default_rate(RATE_W'($urandom_range(1, 1048575)));
        run_random_lines(400);

        wait_idle(8);
        if (mismatches == 0 && due_verdicts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
